// ----- rtl/ffpa_pkg.sv -----
// Shared types and constants of the first-fit page-frame allocator.
package ffpa_pkg;

   localparam int ADDR_W    = 48;
   localparam int SIZE_W    = 32;
   localparam int OWNER_W   = 8;
   localparam int RFRAMES_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_FRAMES = 2'd1;

   // request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [SIZE_W-1:0]  size_bytes;
      logic [ADDR_W-1:0]  address;
      logic [OWNER_W-1:0] owner_id;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic              ok;
   } rsp_type;

endpackage

// ----- rtl/first_fit_page_frame_allocator.sv -----
// First-fit contiguous page-frame allocator: sequencer, frame map memory, shared multiplier.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   req      | req_valid / req_stall | ffpa_pkg::req_type (mode, size, addr, owner)
//   rsp      | rsp_valid / rsp_stall | ffpa_pkg::rsp_type (result_address, ok)
//   csr      | csr_valid / csr_ready | csr_index, csr_wdata (region base, frames)
//
// One request is worked at a time; req_stall is low only in the idle state.
// Allocate: a page-count step, a check step, a scan of the frame map at one frame
//   per cycle (bound by the single memory read port), a write per page marked, a
//   multiply step, a reply step; a failed check or scan goes straight to the reply.
// Free: a page-count step, multiplies of page count and region size, a region check, a
//   start-frame step, a write per page cleared, a reply step; a failed check replies.
// PAGE_BYTES must be a power of two, which the block does not enforce; page counts and frame numbers are shifts.
// After reset a clearing pass writes every frame with req_stall high;
//   csr writes are taken throughout (csr_ready is always high).
// The reply waits in its output register while rsp_stall is high; the next request is
//   taken as soon as the reply is loaded.
module first_fit_page_frame_allocator #(
   parameter int MAX_FRAMES = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ffpa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ffpa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffpa_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int AW      = ffpa_pkg::ADDR_W;
   localparam int OW      = ffpa_pkg::OWNER_W;
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int REM_W   = $clog2(PAGE_BYTES);
   // page count of a 32-bit size, rounded up, fits here
   localparam int PAGES_W = 34 - REM_W;
   localparam int MUL_W   = PAGES_W + REM_W + 1;
   localparam int WORD_W  = OW + 1;

   localparam logic [REM_W:0]                   PAGE_C   = (REM_W+1)'(PAGE_BYTES);
   localparam logic [ffpa_pkg::SIZE_W:0]        ROUND_C  = (ffpa_pkg::SIZE_W+1)'(PAGE_BYTES - 1);
   localparam logic [FRAME_W-1:0]               LAST_FRM = FRAME_W'(MAX_FRAMES - 1);

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b000_0000_0001,
      ST_IDLE   = 11'b000_0000_0010,
      ST_DIV    = 11'b000_0000_0100,
      ST_A_CHK  = 11'b000_0000_1000,
      ST_SCAN   = 11'b000_0001_0000,
      ST_MARK   = 11'b000_0010_0000,
      ST_A_MUL  = 11'b000_0100_0000,
      ST_F_MULP = 11'b000_1000_0000,
      ST_F_MULF = 11'b001_0000_0000,
      ST_F_CHK  = 11'b010_0000_0000,
      ST_RESP   = 11'b100_0000_0000
   } state_type;

   // frame map: bit OW is the used flag, the rest the owner tag
   logic [WORD_W-1:0] frame_mem [MAX_FRAMES];

   state_type                         state_ff, state_in;
   logic [AW-1:0]                     base_ff, base_in;
   logic [ffpa_pkg::RFRAMES_W-1:0]    rframes_ff, rframes_in;
   logic                              mode_ff, mode_in;
   logic [AW-1:0]                     addr_ff, addr_in;
   logic [OW-1:0]                     owner_ff, owner_in;
   logic [AW-1:0]                     div_ff, div_in;
   logic                              div_off_ff, div_off_in;
   logic [PAGES_W-1:0]                pages_ff, pages_in;
   logic [FRAME_W-1:0]                scan_idx_ff, scan_idx_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [FRAME_W-1:0]                chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]                  run_ff, run_in;
   logic [FRAME_W-1:0]                start_ff, start_in;
   logic [FRAME_W-1:0]                mark_idx_ff, mark_idx_in;
   logic [CNT_W-1:0]                  mark_cnt_ff, mark_cnt_in;
   logic [MUL_W-1:0]                  mul_ff, mul_in;
   logic [AW:0]                       run_end_ff, run_end_in;
   logic                              ok_ff, ok_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::rsp_type                 rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0]                 rd_word_ff;

   // memory port controls
   logic                              mem_we;
   logic [FRAME_W-1:0]                mem_wa;
   logic [WORD_W-1:0]                 mem_wd;
   logic                              mem_re;
   logic [FRAME_W-1:0]                mem_ra;

   logic [CNT_W-1:0]                  frames_eff;
   logic [PAGES_W-1:0]                mul_a;
   logic                              frame_used;
   logic [CNT_W-1:0]                  run_nx;
   logic [CNT_W-1:0]                  start_ext;
   logic [AW:0]                       region_end;
   logic [AW-1:0]                     alloc_addr;
   logic                              req_take;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame count above the map size acts as the map size
   always_comb begin
      if (32'(rframes_ff) > 32'(MAX_FRAMES)) begin
         frames_eff = CNT_W'(MAX_FRAMES);
      end else begin
         frames_eff = CNT_W'(rframes_ff);
      end
   end

   // shared constant multiplier operand
   always_comb begin
      unique case (state_ff)
         ST_F_MULP: mul_a = pages_ff;
         ST_F_MULF: mul_a = PAGES_W'(frames_eff);
         default:   mul_a = PAGES_W'(start_ff);
      endcase
   end

   assign frame_used = rd_word_ff[OW];
   assign run_nx     = frame_used ? '0 : run_ff + 1'b1;
   assign start_ext  = CNT_W'(chk_idx_ff) + 1'b1 - run_nx;
   assign region_end = (AW+1)'(base_ff) + (AW+1)'(mul_ff);
   assign alloc_addr = base_ff + AW'(mul_ff);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      rframes_in   = rframes_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      owner_in     = owner_ff;
      div_in       = div_ff;
      div_off_in   = div_off_ff;
      pages_in     = pages_ff;
      scan_idx_in  = scan_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      mark_idx_in  = mark_idx_ff;
      mark_cnt_in  = mark_cnt_ff;
      mul_in       = mul_ff;
      run_end_in   = run_end_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = mark_idx_ff;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = scan_idx_ff;

      if (csr_valid && csr_ready) begin
         priority if (csr_index == ffpa_pkg::CSR_REGION_BASE) begin
            base_in = csr_wdata[AW-1:0];
         end else if (csr_index == ffpa_pkg::CSR_REGION_FRAMES) begin
            rframes_in = csr_wdata[ffpa_pkg::RFRAMES_W-1:0];
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mark_idx_in = mark_idx_ff + 1'b1;
            if (mark_idx_ff == LAST_FRM) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               mode_in    = req_data.mode;
               addr_in    = req_data.address;
               owner_in   = req_data.owner_id;
               div_in     = AW'({1'b0, req_data.size_bytes} + ROUND_C);
               div_off_in = 1'b0;
               state_in   = ST_DIV;
            end
         end

         ST_DIV: begin
            // division by the page size is a shift
            if (div_off_ff) begin
               // start frame of the run to free
               mark_idx_in = div_ff[REM_W +: FRAME_W];
               mark_cnt_in = CNT_W'(pages_ff);
               state_in    = ST_MARK;
            end else begin
               pages_in = div_ff[REM_W +: PAGES_W];
               state_in = (mode_ff == ffpa_pkg::MODE_ALLOC) ? ST_A_CHK : ST_F_MULP;
            end
         end

         ST_A_CHK: begin
            scan_idx_in = '0;
            run_in      = '0;
            if (pages_ff == '0 || AW'(pages_ff) > AW'(frames_eff)) begin
               ok_in    = 1'b0;
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // read one frame ahead while the previous read is checked
            if ((CNT_W+1)'(scan_idx_ff) < (CNT_W+1)'(frames_eff)) begin
               mem_re      = 1'b1;
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               run_in = run_nx;
               if (!frame_used && run_nx == CNT_W'(pages_ff)) begin
                  start_in    = start_ext[FRAME_W-1:0];
                  mark_idx_in = start_ext[FRAME_W-1:0];
                  mark_cnt_in = run_nx;
                  state_in    = ST_MARK;
               end else if (CNT_W'(chk_idx_ff) == frames_eff - 1'b1) begin
                  ok_in    = 1'b0;
                  state_in = ST_RESP;
               end
            end
         end

         ST_MARK: begin
            mem_we      = 1'b1;
            mem_wd      = (mode_ff == ffpa_pkg::MODE_ALLOC) ? {1'b1, owner_ff} : '0;
            mark_idx_in = mark_idx_ff + 1'b1;
            mark_cnt_in = mark_cnt_ff - 1'b1;
            if (mark_cnt_ff == CNT_W'(1)) begin
               ok_in    = 1'b1;
               state_in = (mode_ff == ffpa_pkg::MODE_ALLOC) ? ST_A_MUL : ST_RESP;
            end
         end

         ST_A_MUL: begin
            mul_in   = {{(REM_W+1){1'b0}}, mul_a} * {{PAGES_W{1'b0}}, PAGE_C};
            state_in = ST_RESP;
         end

         ST_F_MULP: begin
            mul_in   = {{(REM_W+1){1'b0}}, mul_a} * {{PAGES_W{1'b0}}, PAGE_C};
            state_in = ST_F_MULF;
         end

         ST_F_MULF: begin
            run_end_in = (AW+1)'(addr_ff) + (AW+1)'(mul_ff);
            mul_in     = {{(REM_W+1){1'b0}}, mul_a} * {{PAGES_W{1'b0}}, PAGE_C};
            state_in   = ST_F_CHK;
         end

         ST_F_CHK: begin
            if (pages_ff != '0 && addr_ff >= base_ff && run_end_ff <= region_end) begin
               div_in     = addr_ff - base_ff;
               div_off_in = 1'b1;
               state_in   = ST_DIV;
            end else begin
               ok_in    = 1'b0;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = ok_ff;
               rsp_data_in.result_address =
                  (ok_ff && mode_ff == ffpa_pkg::MODE_ALLOC) ? alloc_addr : '0;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         rframes_ff   <= '0;
         mark_idx_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rframes_ff   <= rframes_in;
         mark_idx_ff  <= mark_idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      owner_ff    <= owner_in;
      div_ff      <= div_in;
      div_off_ff  <= div_off_in;
      pages_ff    <= pages_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      mark_cnt_ff <= mark_cnt_in;
      mul_ff      <= mul_in;
      run_end_ff  <= run_end_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // frame map, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_word_ff <= frame_mem[mem_ra];
      end
   end

endmodule

// ----- rtl/ffpa_checker.sv -----
// Port-level checks of the first-fit page-frame allocator, bound to the top level.
module ffpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ffpa_pkg::rsp_type rsp_data
);

   // clearing pass follows reset, so no request is taken straight after it
   a_stall_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing pass");

   // a request keeps the allocator busy: req_stall is high right after acceptance
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // failed requests report address zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.result_address == '0)
      else $error("failed reply carries an address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("reply dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("reply changed while stalled");

endmodule

bind first_fit_page_frame_allocator ffpa_checker u_ffpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
